// ===== rtl/ipd_pkg.sv =====
// Shared types, constants and helpers of the pulse-distance infrared decoder.
`default_nettype none

package ipd_pkg;

  localparam int TimeW   = 32;
  localparam int WinW    = 16;
  localparam int BitCntW = 6;
  localparam int WordW   = 32;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  localparam logic [WinW-1:0] StartMinRst = 16'd240;
  localparam logic [WinW-1:0] StartMaxRst = 16'd300;
  localparam logic [WinW-1:0] ZeroMinRst  = 16'd20;
  localparam logic [WinW-1:0] ZeroMaxRst  = 16'd30;
  localparam logic [WinW-1:0] OneMinRst   = 16'd30;
  localparam logic [WinW-1:0] OneMaxRst   = 16'd60;

  typedef enum logic [2:0] {
    RegStartMin = 3'd0,
    RegStartMax = 3'd1,
    RegZeroMin  = 3'd2,
    RegZeroMax  = 3'd3,
    RegOneMin   = 3'd4,
    RegOneMax   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    PhStart    = 3'b001,
    PhEndStart = 3'b010,
    PhBits     = 3'b100
  } phase_e;

  typedef struct packed {
    logic [WinW-1:0] start_min;
    logic [WinW-1:0] start_max;
    logic [WinW-1:0] zero_min;
    logic [WinW-1:0] zero_max;
    logic [WinW-1:0] one_min;
    logic [WinW-1:0] one_max;
  } cfg_t;

  // Open interval test: both bounds are exclusive, so an empty window never matches.
  function automatic logic in_window(logic [TimeW-1:0] t, logic [WinW-1:0] lo,
                                     logic [WinW-1:0] hi);
    logic [TimeW-1:0] lo_w;
    logic [TimeW-1:0] hi_w;
    lo_w = {{(TimeW-WinW){1'b0}}, lo};
    hi_w = {{(TimeW-WinW){1'b0}}, hi};
    return (lo_w < t) && (t < hi_w);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ipd_if.sv =====
// Valid/ready stream interfaces for edge timestamps and decoded code words.
`default_nettype none

interface ipd_edge_if import ipd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] edge_time;
  modport source (output valid, output edge_time, input ready);
  modport sink (input valid, input edge_time, output ready);
endinterface

interface ipd_code_if import ipd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] key_code;
  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/ipd_apb_regs.sv =====
// APB register file holding the six timing window bounds.
`default_nettype none

module ipd_apb_regs import ipd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output      logic [DataW-1:0] prdata,
  output      logic             pready,
  output      cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegStartMin: cfg_d.start_min = pwdata[WinW-1:0];
        RegStartMax: cfg_d.start_max = pwdata[WinW-1:0];
        RegZeroMin:  cfg_d.zero_min  = pwdata[WinW-1:0];
        RegZeroMax:  cfg_d.zero_max  = pwdata[WinW-1:0];
        RegOneMin:   cfg_d.one_min   = pwdata[WinW-1:0];
        RegOneMax:   cfg_d.one_max   = pwdata[WinW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegStartMin: prdata = {{(DataW-WinW){1'b0}}, cfg_q.start_min};
      RegStartMax: prdata = {{(DataW-WinW){1'b0}}, cfg_q.start_max};
      RegZeroMin:  prdata = {{(DataW-WinW){1'b0}}, cfg_q.zero_min};
      RegZeroMax:  prdata = {{(DataW-WinW){1'b0}}, cfg_q.zero_max};
      RegOneMin:   prdata = {{(DataW-WinW){1'b0}}, cfg_q.one_min};
      RegOneMax:   prdata = {{(DataW-WinW){1'b0}}, cfg_q.one_max};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_min <= StartMinRst;
      cfg_q.start_max <= StartMaxRst;
      cfg_q.zero_min  <= ZeroMinRst;
      cfg_q.zero_max  <= ZeroMaxRst;
      cfg_q.one_min   <= OneMinRst;
      cfg_q.one_max   <= OneMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ipd_core.sv =====
// Decoder state machine: classifies each interval and assembles the code word.
`default_nettype none

module ipd_core import ipd_pkg::*; #(
  parameter int CODE_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             step_i,
  input  wire logic [TimeW-1:0] edge_time_i,
  output      logic             res_valid_o,
  output      logic [WordW-1:0] key_code_o
);

  localparam logic [BitCntW:0] LastPos = (BitCntW+1)'(CODE_BITS - 1);

  phase_e             phase_q, phase_d;
  logic [TimeW-1:0]   prev_q, prev_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic [WordW-1:0]   shift_q, shift_d;
  logic [TimeW-1:0]   dt;
  logic               is_start, is_zero, is_one;

  // Elapsed ticks wrap naturally with the free-running counter.
  assign dt       = edge_time_i - prev_q;
  assign is_start = in_window(dt, cfg_i.start_min, cfg_i.start_max);
  assign is_zero  = in_window(dt, cfg_i.zero_min, cfg_i.zero_max);
  assign is_one   = in_window(dt, cfg_i.one_min, cfg_i.one_max);

  always_comb begin
    phase_d     = phase_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    res_valid_o = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PhEndStart: begin
          if (is_start) begin
            prev_d  = edge_time_i;
            phase_d = PhBits;
          end else begin
            phase_d = PhStart;
          end
        end
        PhBits: begin
          if (is_zero || is_one) begin
            prev_d = edge_time_i;
            // Bits beyond the word width are counted but not stored.
            if (!cnt_q[BitCntW-1]) begin
              shift_d[cnt_q[BitCntW-2:0]] = !is_zero;
            end
            if ({1'b0, cnt_q} >= LastPos) begin
              res_valid_o = 1'b1;
              cnt_d       = '0;
              phase_d     = PhStart;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            phase_d = PhStart;
            cnt_d   = '0;
          end
        end
        default: begin
          prev_d  = edge_time_i;
          phase_d = PhEndStart;
        end
      endcase
    end
  end

  assign key_code_o = shift_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      prev_q  <= '0;
      cnt_q   <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ir_pulse_distance_decoder.sv =====
// Top level of the pulse-distance infrared decoder with its stream and APB ports.
`default_nettype none

// Feed one beat per falling edge of the receiver, carrying the captured tick count.
// The block takes one beat every cycle: a beat sits in the input register, the
// decoder state advances on it in a single step and any finished code word lands in
// the output register, so the input and output registers lie between a beat and the
// code word it completes. The single step through the state machine sets that
// rate; the input only stalls while a finished code word is held in the output
// register and the sink does not take it. The window bounds live in six 16-bit APB
// registers (start, zero, one; minimum then maximum, all exclusive) and are to be
// changed only while the decoder is idle.
module ir_pulse_distance_decoder import ipd_pkg::*; #(
  parameter int CODE_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ipd_edge_if.sink              edge_i,
  ipd_code_if.source            code_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output      logic [DataW-1:0] prdata,
  output      logic             pready
);

  cfg_t             cfg;
  logic             in_vld_q, in_vld_d;
  logic [TimeW-1:0] edge_q;
  logic             out_vld_q, out_vld_d;
  logic [WordW-1:0] code_q;
  logic             step;
  logic             res_valid;
  logic [WordW-1:0] key_code;
  logic             in_take;

  ipd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ipd_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .edge_time_i (edge_q),
    .res_valid_o (res_valid),
    .key_code_o  (key_code)
  );

  // The step waits only when a code word is still held and not being taken.
  assign step         = in_vld_q && (!out_vld_q || code_o.ready);
  assign edge_i.ready = !in_vld_q || step;
  assign in_take      = edge_i.valid && edge_i.ready;

  assign code_o.valid    = out_vld_q;
  assign code_o.key_code = code_q;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step && res_valid) begin
      out_vld_d = 1'b1;
    end else if (code_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      edge_q <= edge_i.edge_time;
    end
    if (step && res_valid) begin
      code_q <= key_code;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the pulse-distance infrared decoder: edge stream, windows, code words.
module tb_top;
  import ipd_pkg::*;

  localparam int CodeBits     = 32;
  localparam int NumRegs      = 6;
  localparam int NumSegs      = 7;
  localparam int SegItems     = 200;
  localparam int SegFrames    = 6;
  localparam int SettleCycles = 8;
  localparam int StallLimit   = 5000;
  localparam int unsigned UnusedRegA = 6;
  localparam int unsigned UnusedRegB = 7;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  ipd_edge_if edge_if ();
  ipd_code_if code_if ();

  ir_pulse_distance_decoder #(.CODE_BITS(CodeBits)) u_dut (
    .clk_i,
    .rst_ni,
    .edge_i (edge_if),
    .code_o (code_if),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  logic [TimeW-1:0] pending_edges [$];
  logic [WordW-1:0] expected_codes [$];

  // Shadow copy of the window registers and of the decoder state.
  logic [WinW-1:0]    win_bound [NumRegs];
  phase_e             dec_phase  = PhStart;
  logic [TimeW-1:0]   last_edge  = '0;
  logic [BitCntW-1:0] bit_count  = '0;
  logic [WordW-1:0]   code_shift = '0;

  logic             edge_took;
  logic [TimeW-1:0] gen_now = '0;
  int err_count      = 0;
  int edges_pushed   = 0;
  int edges_accepted = 0;
  int src_idle_pct   = 0;
  int snk_idle_pct   = 0;
  int idle_cycles    = 0;
  int seg_items      = 0;
  int seg_frames     = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic in_open(input logic [TimeW-1:0] t, input logic [WinW-1:0] lo,
                                   input logic [WinW-1:0] hi);
    return (t > TimeW'(lo)) && (t < TimeW'(hi));
  endfunction

  task automatic decode_edge(input logic [TimeW-1:0] now);
    logic [TimeW-1:0] dt;
    logic             bit_val;
    logic             hit;
    int unsigned      pos;
    dt = now - last_edge;
    case (dec_phase)
      PhEndStart: begin
        if (in_open(dt, win_bound[RegStartMin], win_bound[RegStartMax])) begin
          last_edge = now;
          dec_phase = PhBits;
        end else begin
          dec_phase = PhStart;
        end
      end
      PhBits: begin
        hit     = 1'b1;
        bit_val = 1'b0;
        // The zero window wins where the two windows overlap.
        if (in_open(dt, win_bound[RegZeroMin], win_bound[RegZeroMax])) begin
          bit_val = 1'b0;
        end else if (in_open(dt, win_bound[RegOneMin], win_bound[RegOneMax])) begin
          bit_val = 1'b1;
        end else begin
          hit = 1'b0;
        end
        if (!hit) begin
          dec_phase = PhStart;
          bit_count = '0;
        end else begin
          last_edge = now;
          pos = 32'(bit_count);
          if (pos < WordW) code_shift[pos] = bit_val;
          if (pos + 1 >= CodeBits) begin
            expected_codes.push_back(code_shift);
            bit_count = '0;
            dec_phase = PhStart;
          end else begin
            bit_count = BitCntW'(pos + 1);
          end
        end
      end
      default: begin
        last_edge = now;
        dec_phase = PhEndStart;
      end
    endcase
  endtask

  always @(posedge clk_i) begin : mon
    logic [WordW-1:0] want;
    if (!rst_ni) begin
      edge_took <= 1'b0;
    end else begin
      edge_took <= edge_if.valid && edge_if.ready;
      // The code beat is checked before the edge beat, which may queue a newer word.
      if (code_if.valid && code_if.ready) begin
        if (expected_codes.size() == 0) begin
          $error("key_code: unexpected beat, expected none, actual %h", code_if.key_code);
          err_count++;
        end else begin
          want = expected_codes.pop_front();
          if (want !== code_if.key_code) begin
            $error("key_code mismatch: expected %h, actual %h", want, code_if.key_code);
            err_count++;
          end
        end
      end
      if (edge_if.valid && edge_if.ready) begin
        decode_edge(edge_if.edge_time);
        edges_accepted++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      edge_if.valid <= 1'b0;
    end else if (!edge_if.valid || edge_took) begin
      if (pending_edges.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        edge_if.valid     <= 1'b1;
        edge_if.edge_time <= pending_edges.pop_front();
      end else begin
        edge_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    code_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((edge_if.valid && edge_if.ready) || (code_if.valid && code_if.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic can_hit(input logic [WinW-1:0] lo, input logic [WinW-1:0] hi);
    return int'(hi) > int'(lo) + 1;
  endfunction

  function automatic logic [TimeW-1:0] gap_in(input logic [WinW-1:0] lo,
                                              input logic [WinW-1:0] hi);
    return TimeW'(lo) + 32'd1 + $urandom_range(int'(hi) - int'(lo) - 2);
  endfunction

  // Longer than any 16-bit window can hold, so it never matches.
  function automatic logic [TimeW-1:0] far_gap();
    return 32'd65536 + $urandom_range(1 << 20);
  endfunction

  function automatic logic [TimeW-1:0] bad_gap();
    case ($urandom_range(3))
      0:       return far_gap();
      1:       return TimeW'(win_bound[RegZeroMin]);
      2:       return TimeW'(win_bound[RegOneMax]);
      default: return '0;
    endcase
  endfunction

  task automatic push_edge(input logic [TimeW-1:0] t);
    pending_edges.push_back(t);
    gen_now = t;
    edges_pushed++;
    seg_items++;
  endtask

  task automatic wait_edges_done();
    while (edges_accepted != edges_pushed) @(negedge clk_i);
  endtask

  // The decoder has no busy flag, so the task waits on past the empty queue to cover an edge still in the pipeline.
  task automatic wait_idle();
    wait_edges_done();
    while (expected_codes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_frame(input int good_bits);
    logic [WordW-1:0] word;
    int               pick;
    logic [TimeW-1:0] gap;
    pick = $urandom_range(9);
    word = (pick == 0) ? '0 : (pick == 1) ? '1 : WordW'($urandom);
    if ($urandom_range(3) == 0) push_edge($urandom);
    else push_edge(gen_now + far_gap());
    push_edge(gen_now + gap_in(win_bound[RegStartMin], win_bound[RegStartMax]));
    for (int b = 0; b < good_bits; b++) begin
      if ((word[b % WordW] && can_hit(win_bound[RegOneMin], win_bound[RegOneMax])) ||
          !can_hit(win_bound[RegZeroMin], win_bound[RegZeroMax]))
        gap = gap_in(win_bound[RegOneMin], win_bound[RegOneMax]);
      else
        gap = gap_in(win_bound[RegZeroMin], win_bound[RegZeroMax]);
      push_edge(gen_now + gap);
    end
    if (good_bits < CodeBits) push_edge(gen_now + bad_gap());
  endtask

  task automatic push_unit();
    int   roll;
    int   n;
    logic formable;
    wait_edges_done();
    // A window miss always drops the decoder back to awaiting a start edge.
    if (dec_phase != PhStart) push_edge(gen_now + far_gap());
    formable = can_hit(win_bound[RegStartMin], win_bound[RegStartMax]) &&
               (can_hit(win_bound[RegZeroMin], win_bound[RegZeroMax]) ||
                can_hit(win_bound[RegOneMin], win_bound[RegOneMax]));
    roll = $urandom_range(99);
    if (formable && roll < 70) begin
      push_frame(CodeBits);
      seg_frames++;
    end else if (formable && roll < 85) begin
      push_frame($urandom_range(CodeBits - 1));
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        if ($urandom_range(1) == 0) push_edge($urandom);
        else push_edge(gen_now + $urandom_range(400));
      end
    end
  endtask

  task automatic write_window(input int unsigned idx, input logic [WinW-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AddrW'(idx * 4);
    pwdata  = {16'($urandom), val};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    if (idx < NumRegs) begin
      win_bound[idx] = val;
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clk_i);
      penable = 1'b1;
      @(posedge clk_i);
      if (prdata[WinW-1:0] !== val) begin
        $error("prdata mismatch at register %0d: expected %h, actual %h",
               idx, val, prdata[WinW-1:0]);
        err_count++;
      end
      @(negedge clk_i);
    end
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_windows(input int seg);
    int lo;
    case (seg)
      1: begin
        lo = $urandom_range(65000);
        write_window(RegStartMin, WinW'(lo));
        write_window(RegStartMax, WinW'(lo + 2 + $urandom_range(500)));
        lo = $urandom_range(1000);
        write_window(RegZeroMin, WinW'(lo));
        write_window(RegZeroMax, WinW'(lo + 2 + $urandom_range(200)));
        lo = $urandom_range(1000);
        write_window(RegOneMin, WinW'(lo));
        write_window(RegOneMax, WinW'(lo + 2 + $urandom_range(300)));
      end
      2: begin
        // Widest start and zero windows; the one window is inverted and so empty.
        write_window(RegStartMin, 16'd0);
        write_window(RegStartMax, 16'hFFFF);
        write_window(RegZeroMin, 16'd0);
        write_window(RegZeroMax, 16'hFFFF);
        write_window(RegOneMin, 16'hFFFF);
        write_window(RegOneMax, 16'd0);
        write_window(UnusedRegA, WinW'($urandom));
        write_window(UnusedRegB, WinW'($urandom));
      end
      3: begin
        write_window(RegStartMin, 16'd1000);
        write_window(RegStartMax, 16'd1100);
        write_window(RegZeroMin, 16'd100);
        write_window(RegZeroMax, 16'd100);
        write_window(RegOneMin, 16'd0);
        write_window(RegOneMax, 16'hFFFF);
      end
      4: begin
        write_window(RegStartMin, 16'd100);
        write_window(RegStartMax, 16'd200);
        write_window(RegZeroMin, 16'd10);
        write_window(RegZeroMax, 16'd50);
        write_window(RegOneMin, 16'd20);
        write_window(RegOneMax, 16'd80);
      end
      5: begin
        // Each window admits a single value.
        write_window(RegStartMin, 16'hFFFD);
        write_window(RegStartMax, 16'hFFFF);
        write_window(RegZeroMin, 16'd0);
        write_window(RegZeroMax, 16'd2);
        write_window(RegOneMin, 16'd2);
        write_window(RegOneMax, 16'd4);
      end
      default: begin
        write_window(RegStartMin, StartMinRst);
        write_window(RegStartMax, StartMaxRst);
        write_window(RegZeroMin, ZeroMinRst);
        write_window(RegZeroMax, ZeroMaxRst);
        write_window(RegOneMin, OneMinRst);
        write_window(RegOneMax, OneMaxRst);
      end
    endcase
  endtask

  initial begin
    rst_ni            = 1'b0;
    edge_if.valid     = 1'b0;
    edge_if.edge_time = '0;
    code_if.ready     = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    win_bound[RegStartMin] = StartMinRst;
    win_bound[RegStartMax] = StartMaxRst;
    win_bound[RegZeroMin]  = ZeroMinRst;
    win_bound[RegZeroMax]  = ZeroMaxRst;
    win_bound[RegOneMin]   = OneMinRst;
    win_bound[RegOneMax]   = OneMaxRst;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct = 16;
    snk_idle_pct = 67;
    // Directed edges under the reset windows: counter extremes, wrap-around, boundaries.
    push_edge(32'h0000_0000);
    push_edge(32'hFFFF_FFFF);
    push_edge(32'hFFFF_FFFF);
    push_edge(32'd240);
    push_edge(32'd265);
    push_edge(32'd310);
    push_edge(32'd340);
    push_edge(32'd400);
    push_edge(32'd700);
    push_edge(32'd1000);
    push_edge(32'd1240);
    push_edge(32'd2000);
    push_edge(32'd2299);
    push_edge(32'd2320);
    push_edge(32'd2379);
    push_edge(32'd2439);
    push_edge(32'h8000_0000);
    push_edge(32'h8000_010E);
    push_edge(32'h8000_010E);
    push_edge(32'h7FFF_FFFF);
    push_edge(32'h8000_00F9);
    wait_idle();

    for (int seg = 0; seg < NumSegs; seg++) begin
      if (seg < 3) begin
        src_idle_pct = 16;
        snk_idle_pct = 67;
      end else if (seg < 5) begin
        src_idle_pct = 67;
        snk_idle_pct = 16;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (seg > 0) set_windows(seg);
      seg_items  = 0;
      seg_frames = 0;
      while (seg_items < SegItems || seg_frames < SegFrames) push_unit();
      wait_idle();
    end

    repeat (SettleCycles) @(negedge clk_i);
    if (expected_codes.size() != 0) begin
      $error("key_code: %0d expected words never arrived", expected_codes.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ipd_pkg.sv
rtl/ipd_if.sv
rtl/ipd_apb_regs.sv
rtl/ipd_core.sv
rtl/ir_pulse_distance_decoder.sv
verif/tb_top.sv
